### hw/rtl/tmvf_pkg.sv
// tmvf_pkg: shared constants, state encoding and control structs for the
// trimmed mean voltage filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmvf_pkg;

   // default sizing, handed down from the top level
   localparam int WINDOW_SIZE_DEF = 16;
   localparam int SAMPLE_BITS_DEF = 12;

   // divider gain, unsigned Q4.12
   localparam int              GAIN_W     = 16;
   localparam int              GAIN_FRAC  = 12;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6144;

   // result field
   localparam int             OUT_W   = 16;
   localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

   // a quarter of the window is dropped at each end
   localparam int TRIM_DIV = 4;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUM,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } back_state_type;

   // front to queue: write strobe and end-of-window tag
   typedef struct packed {
      logic push;
      logic last;
   } push_type;

   // queue to back: head status
   typedef struct packed {
      logic valid;
      logic last;
   } head_type;

endpackage : tmvf_pkg

`default_nettype wire

### hw/rtl/tmvf_front.sv
// tmvf_front: accepts sample items and tags the one that closes a window.
// Depends on tmvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmvf_front import tmvf_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int DATA_W      = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [DATA_W-1:0]      req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   q_full,
   output push_type                    push_o,
   output logic      [SAMPLE_BITS-1:0] sample_o
);

   localparam int CNT_W = $clog2(WINDOW_SIZE);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             last;

   // handshake and window position
   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign last       = (cnt_ff == CNT_W'(WINDOW_SIZE - 1));

   assign push_o.push = accept;
   assign push_o.last = last;
   assign sample_o    = req_tdata[SAMPLE_BITS-1:0];

   // samples seen in the current window
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule : tmvf_front

`default_nettype wire

### hw/rtl/tmvf_queue.sv
// tmvf_queue: short first-in first-out queue of tagged samples between the
// front and the back. Depends on tmvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmvf_queue import tmvf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire push_type               push_i,
   input  wire logic [SAMPLE_BITS-1:0] sample_i,
   output logic                        full_o,
   input  wire logic                   pop_i,
   output head_type                    head_o,
   output logic      [SAMPLE_BITS-1:0] head_sample_o
);

   localparam int ENT_W = SAMPLE_BITS + 1;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [ENT_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             empty;
   logic             pop;
   logic [ENT_W-1:0] head_ent;

   assign empty  = (cnt_ff == '0);
   assign full_o = (cnt_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign pop    = pop_i && !empty;

   // head of queue
   assign head_ent      = slot_ff[rd_ff];
   assign head_o.valid  = !empty;
   assign head_o.last   = head_ent[SAMPLE_BITS];
   assign head_sample_o = head_ent[SAMPLE_BITS-1:0];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push_i.push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push_i.push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push_i.push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_i.push) begin
         slot_ff[wr_ff] <= {push_i.last, sample_i};
      end
   end

endmodule : tmvf_queue

`default_nettype wire

### hw/rtl/tmvf_back.sv
// tmvf_back: sorted insertion row, trimmed sum, reciprocal divide by the kept
// count, gain multiply, saturation and result register. Depends on tmvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmvf_back import tmvf_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire head_type               head_i,
   input  wire logic [SAMPLE_BITS-1:0] head_sample_i,
   output logic                        pop_o,
   input  wire logic                   csr_we,
   input  wire logic [GAIN_W-1:0]      csr_wdata,
   output logic      [OUT_W-1:0]       rsp_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready
);

   localparam int TRIM   = WINDOW_SIZE / TRIM_DIV;
   localparam int KEEP   = WINDOW_SIZE - 2 * TRIM;
   localparam int FILL_W = $clog2(WINDOW_SIZE);
   localparam int KEEP_W = $clog2(KEEP + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(KEEP);
   localparam int PROD_W = SAMPLE_BITS + GAIN_W;
   // rounded-up reciprocal of the kept count, exact for every sum below 2**SUM_W
   localparam int RCP_SH = SUM_W + $clog2(KEEP);
   localparam int RCP_W  = SUM_W + 1;
   localparam int QP_W   = SUM_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_SH) + 64'(KEEP) - 64'd1) / 64'(KEEP));

   back_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] row_ff [WINDOW_SIZE];
   logic [SAMPLE_BITS-1:0] ins_row [WINDOW_SIZE];
   logic [WINDOW_SIZE-1:0] le;
   logic [FILL_W-1:0]      fill_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [KEEP_W-1:0]      sum_cnt_ff;
   logic [QP_W-1:0]        quo_prod;
   logic [SAMPLE_BITS-1:0] quo_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [PROD_W-1:0]      shifted;
   logic [GAIN_W-1:0]      gain_ff;
   logic [OUT_W-1:0]       out_data_ff;
   logic                   out_valid_ff;

   logic sum_done;
   logic do_pop, do_sum, do_div, do_mul, do_out;

   assign sum_done = (sum_cnt_ff == KEEP_W'(KEEP - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (head_i.valid && head_i.last) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      do_pop = 1'b0;
      do_sum = 1'b0;
      do_div = 1'b0;
      do_mul = 1'b0;
      do_out = 1'b0;
      case (state_ff)
         ST_LOAD: do_pop = head_i.valid;
         ST_SUM:  do_sum = 1'b1;
         ST_DIV:  do_div = 1'b1;
         ST_MUL:  do_mul = 1'b1;
         ST_OUT:  do_out = !out_valid_ff || rsp_tready;
         default: do_pop = 1'b0;
      endcase
   end

   assign pop_o = do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // insertion position: entries past the fill count act as larger than any sample
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         le[i] = (FILL_W'(i) < fill_ff) && (row_ff[i] <= head_sample_i);
      end
      ins_row[0] = le[0] ? row_ff[0] : head_sample_i;
      for (int i = 1; i < WINDOW_SIZE; i++) begin
         ins_row[i] = le[i] ? row_ff[i] : (le[i-1] ? head_sample_i : row_ff[i-1]);
      end
   end

   // sorted row: insert on pop, shift toward zero while summing
   always_ff @(posedge clock) begin
      if (do_pop) begin
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            row_ff[i] <= ins_row[i];
         end
      end else if (do_sum) begin
         for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
            row_ff[i] <= row_ff[i+1];
         end
      end
   end

   // fill count, cleared when the closing sample goes in
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (do_pop) begin
         fill_ff <= head_i.last ? '0 : fill_ff + 1'b1;
      end
   end

   // trimmed sum, one kept entry per cycle from the fixed tap
   assign sum_in = sum_ff + SUM_W'(row_ff[TRIM]);

   always_ff @(posedge clock) begin
      if (do_pop) begin
         sum_ff     <= '0;
         sum_cnt_ff <= '0;
      end else if (do_sum) begin
         sum_ff     <= sum_in;
         sum_cnt_ff <= sum_cnt_ff + 1'b1;
      end
   end

   // divide by the kept count: multiply by the reciprocal, drop the scale bits
   assign quo_prod = QP_W'(sum_ff) * QP_W'(RCP);

   always_ff @(posedge clock) begin
      if (do_div) begin
         quo_ff <= SAMPLE_BITS'(quo_prod >> RCP_SH);
      end
   end

   // gain multiply
   always_ff @(posedge clock) begin
      if (do_mul) begin
         prod_ff <= PROD_W'(quo_ff) * PROD_W'(gain_ff);
      end
   end

   // drop fraction bits and saturate
   assign shifted = prod_ff >> GAIN_FRAC;

   always_ff @(posedge clock) begin
      if (do_out) begin
         out_data_ff <= (shifted > PROD_W'(OUT_MAX)) ? OUT_MAX : shifted[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (do_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tdata  = out_data_ff;
   assign rsp_tvalid = out_valid_ff;

   // divider gain register
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         gain_ff <= csr_wdata;
      end
   end

endmodule : tmvf_back

`default_nettype wire

### hw/rtl/trimmed_mean_voltage_filter.sv
// Trimmed mean voltage filter, top level. Depends on tmvf_pkg, tmvf_front,
// tmvf_queue and tmvf_back.
// Throughput: one sample item per cycle while a window fills; the back end then sums,
// divides, scales and outputs the result, and input stalls once the two-entry queue fills.
// Reset: synchronous, clears the window, queue and result; gain returns to 1.5.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_voltage_filter import tmvf_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // sample item: [SAMPLE_BITS-1:0] sample_mv, zero padded above
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // result item: [15:0] voltage_mv
   output logic      [OUT_W-1:0]  rsp_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // divider_gain_q12 write
   input  wire logic              csr_we,
   input  wire logic [GAIN_W-1:0] csr_wdata
);

   push_type               push;
   head_type               head;
   logic [SAMPLE_BITS-1:0] front_sample;
   logic [SAMPLE_BITS-1:0] head_sample;
   logic                   q_full;
   logic                   pop;

   // accept and tag
   tmvf_front #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_W      (DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .q_full     (q_full),
      .push_o     (push),
      .sample_o   (front_sample)
   );

   // decoupling queue
   tmvf_queue #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .push_i        (push),
      .sample_i      (front_sample),
      .full_o        (q_full),
      .pop_i         (pop),
      .head_o        (head),
      .head_sample_o (head_sample)
   );

   // sort, trim, average, scale
   tmvf_back #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_i        (head),
      .head_sample_i (head_sample),
      .pop_o         (pop),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready)
   );

endmodule : trimmed_mean_voltage_filter

`default_nettype wire

### hw/rtl/tmvf_checker.sv
// tmvf_checker: port-level assertions for the trimmed mean voltage filter,
// bound to the top level. Depends on tmvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmvf_checker import tmvf_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [OUT_W-1:0] rsp_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready
);

   localparam int CNT_W = $clog2(WINDOW_SIZE);

   logic [CNT_W-1:0] win_ff, win_in;
   logic [3:0]       pend_ff, pend_in;
   logic             in_acc, out_acc, closes;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;
   assign closes  = in_acc && (win_ff == CNT_W'(WINDOW_SIZE - 1));

   // windows completed at the input but not yet delivered
   always_comb begin
      win_in  = win_ff;
      pend_in = pend_ff;
      if (in_acc) begin
         win_in = closes ? '0 : win_ff + 1'b1;
      end
      if (closes && !out_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (out_acc && !closes) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         pend_ff <= '0;
      end else begin
         win_ff  <= win_in;
         pend_ff <= pend_in;
      end
   end

   // reset leaves an empty queue and no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result without a completed window
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 4'd0)
      else $error("result without a completed window");

   // at most two finished windows wait for delivery
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 4'd2)
      else $error("too many undelivered windows");

endmodule : tmvf_checker

bind trimmed_mean_voltage_filter tmvf_checker #(
   .WINDOW_SIZE (WINDOW_SIZE)
) u_tmvf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

### verif/trimmed_mean_voltage_filter_tb.sv
// trimmed_mean_voltage_filter_tb: self-checking bench for the trimmed mean voltage filter.
// Streams sample windows with random gaps and stalls, predicts each corrected voltage
// and compares it with the result stream. Depends on tmvf_pkg and trimmed_mean_voltage_filter.
`timescale 1ns / 1ps

module trimmed_mean_voltage_filter_tb;
   import tmvf_pkg::*;

   localparam int WINDOW      = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int TRIM        = WINDOW / TRIM_DIV;
   localparam int KEEP        = WINDOW - 2 * TRIM;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   // settle time after draining, well past the back end's work on one window
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 3000;
   localparam int REPORT_LIMIT  = 10;

   // content shapes for one window
   typedef enum logic [2:0] {
      SHAPE_UNIFORM,
      SHAPE_CLUSTER,
      SHAPE_FLAT,
      SHAPE_RAMP,
      SHAPE_EXTREME
   } window_shape_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [OUT_W-1:0]  rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_we     = 1'b0;
   logic [GAIN_W-1:0] csr_wdata  = '0;

   // predictor state
   logic [GAIN_W-1:0]      gain_q12 = GAIN_RESET;
   logic [SAMPLE_BITS-1:0] window_fill [WINDOW];
   int                     fill_count = 0;
   logic [OUT_W-1:0]       pending_voltages [$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  steady_flow = 1'b0;

   trimmed_mean_voltage_filter #(
      .WINDOW_SIZE (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short pauses, a few long ones
   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // sort the completed window, average the middle half, apply gain and saturate
   function automatic logic [OUT_W-1:0] trimmed_voltage();
      logic [SAMPLE_BITS-1:0] sorted [WINDOW];
      logic [SAMPLE_BITS-1:0] key;
      int                     j;
      logic [31:0]            sum;
      logic [31:0]            mean;
      logic [63:0]            product;
      for (int i = 0; i < WINDOW; i++) sorted[i] = window_fill[i];
      for (int i = 1; i < WINDOW; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      sum = '0;
      for (int i = TRIM; i < TRIM + KEEP; i++) sum += 32'(sorted[i]);
      // both the mean and the scaled product truncate
      mean = sum / KEEP;
      product = (64'(mean) * 64'(gain_q12)) >> GAIN_FRAC;
      if (product > 64'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return product[OUT_W-1:0];
   endfunction

   // store one accepted sample, predict a voltage when the window closes
   task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] sample);
      window_fill[fill_count] = sample;
      fill_count++;
      if (fill_count == WINDOW) begin
         pending_voltages.push_back(trimmed_voltage());
         fill_count = 0;
      end
   endtask

   // drive one sample item and wait for its acceptance
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
      int gap;
      gap = (steady_flow || $urandom_range(0, 99) < 60) ? 0 : pick_pause();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(DATA_W - SAMPLE_BITS){1'b0}}, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_sample(sample);
   endtask

   // build and send one full window of the given shape
   task automatic send_window(input window_shape_type shape);
      logic [SAMPLE_BITS-1:0] values [WINDOW];
      int base;
      int step;
      int v;
      base = $urandom_range(0, 4095);
      step = $urandom_range(0, 270);
      for (int i = 0; i < WINDOW; i++) begin
         case (shape)
            SHAPE_UNIFORM: begin
               v = $urandom_range(0, 4095);
            end
            SHAPE_CLUSTER: begin
               // tight group with the odd outlier at a rail
               v = base + $urandom_range(0, 40) - 20;
               if ($urandom_range(0, 99) < 15) v = $urandom_range(0, 1) ? 4095 : 0;
            end
            SHAPE_FLAT: begin
               v = base;
            end
            SHAPE_RAMP: begin
               v = (base < 2048) ? base + i * step : base - i * step;
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: v = 0;
                  1: v = 4095;
                  default: v = $urandom_range(0, 4095);
               endcase
            end
         endcase
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         values[i] = SAMPLE_BITS'(v);
      end
      for (int i = 0; i < WINDOW; i++) send_sample(values[i]);
   endtask

   function automatic window_shape_type pick_shape();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return SHAPE_UNIFORM;
         4, 5:       return SHAPE_CLUSTER;
         6:          return SHAPE_FLAT;
         7:          return SHAPE_RAMP;
         default:    return SHAPE_EXTREME;
      endcase
   endfunction

   // wait for every predicted voltage, then let the back end settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_voltages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // gain write, only while the block is idle
   task automatic write_gain(input logic [GAIN_W-1:0] gain);
      csr_we    <= 1'b1;
      csr_wdata <= gain;
      @(posedge clock);
      csr_we    <= 1'b0;
      gain_q12 = gain;
      @(posedge clock);
   endtask

   // reset gain; rail outliers that must be trimmed, fractional mean
   task automatic test_default_gain();
      logic [SAMPLE_BITS-1:0] samples [WINDOW];
      samples = '{12'd4095, 12'd1003, 12'd0, 12'd1006, 12'd1000, 12'd4095, 12'd1007, 12'd0,
                  12'd1001, 12'd4095, 12'd1005, 12'd0, 12'd1002, 12'd4095, 12'd1004, 12'd0};
      // window not yet full gives nothing until the sixteenth item
      for (int i = 0; i < WINDOW; i++) send_sample(samples[i]);
      drain();
   endtask

   // largest gain on a window alternating full-scale and 0xAAA samples, then random windows
   task automatic test_max_gain();
      write_gain('1);
      for (int i = 0; i < WINDOW; i++) send_sample((i % 2 == 0) ? SAMPLE_MAX : 12'hAAA);
      for (int i = 0; i < 5; i++) send_window(pick_shape());
      drain();
   endtask

   // zero gain forces every result to zero
   task automatic test_zero_gain();
      write_gain('0);
      for (int i = 0; i < WINDOW; i++) send_sample((i % 2 == 0) ? 12'h555 : 12'hAAA);
      for (int i = 0; i < 3; i++) send_window(pick_shape());
      drain();
   endtask

   // unity gain passes the trimmed mean straight through
   task automatic test_unity_gain();
      write_gain(16'd4096);
      send_window(SHAPE_FLAT);
      for (int i = 0; i < 8; i++) send_window(pick_shape());
      drain();
   endtask

   // a sequence of random gains, each with its own set of windows
   task automatic test_random_gains();
      for (int phase = 0; phase < 8; phase++) begin
         write_gain((phase == 0) ? 16'd1 : GAIN_W'($urandom_range(0, 65535)));
         for (int i = 0; i < 6; i++) send_window(pick_shape());
         drain();
      end
   endtask

   // back to back windows with no gaps or stalls, queue kept full
   task automatic test_steady_stream();
      write_gain(GAIN_RESET);
      steady_flow = 1'b1;
      for (int i = 0; i < 10; i++) send_window(pick_shape());
      drain();
      steady_flow = 1'b0;
   endtask

   task automatic flag_mismatch(input string what, input logic [OUT_W-1:0] want,
                                input logic [OUT_W-1:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t: %s voltage_mv expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_voltages.size() == 0) begin
            flag_mismatch("unexpected result,", '0, rsp_tdata);
         end else if (pending_voltages[0] !== rsp_tdata) begin
            flag_mismatch("mismatch,", pending_voltages[0], rsp_tdata);
            void'(pending_voltages.pop_front());
         end else begin
            void'(pending_voltages.pop_front());
         end
      end
   end

   // result side back pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 99) < 25) stall_left <= pick_pause();
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("trimmed_mean_voltage_filter regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_gain();
      test_max_gain();
      test_zero_gain();
      test_unity_gain();
      test_random_gains();
      test_steady_stream();
      if (error_count == 0) begin
         $display("trimmed_mean_voltage_filter regression: pass");
      end else begin
         $display("trimmed_mean_voltage_filter regression: fail");
      end
      $finish;
   end

endmodule
